// File: sv/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg: shared definitions for the Caesar frequency breaker
// Opcodes, the classified transaction record and the ASCII letter constants.
// ----------------------------------------------------------------------------
package cfb_pkg;

   localparam int DEFAULT_COUNT_WIDTH = 32;
   localparam int QUEUE_DEPTH         = 2;

   localparam int          LETTERS      = 26;
   localparam logic [4:0]  LETTER_COUNT = 5'd26;
   localparam logic [4:0]  LETTER_E_IDX = 5'd4;
   localparam logic [7:0]  UPPER_A      = 8'd65;
   localparam logic [7:0]  UPPER_Z      = 8'd90;
   localparam logic [7:0]  LOWER_A      = 8'd97;
   localparam logic [7:0]  LOWER_Z      = 8'd122;

   typedef enum logic [1:0] {
      OP_COUNT   = 2'd0,
      OP_DECRYPT = 2'd1,
      OP_CLEAR   = 2'd2
   } cfb_opcode_type;

   typedef struct packed {
      cfb_opcode_type op;
      logic           is_letter;
      logic           is_upper;
      logic [4:0]     letter;
      logic [7:0]     raw;
   } cfb_item_type;

endpackage

// File: sv/cfb_front.sv
// ----------------------------------------------------------------------------
// cfb_front: request intake and classification
// Accepts a transaction, drops the unused opcode and tags letters by case and
// alphabet position before handing the record to the queue.
// ----------------------------------------------------------------------------
module cfb_front (
   input  logic                  start,
   input  logic [1:0]            req_opcode,
   input  logic [7:0]            req_in_byte,
   input  logic                  queue_full,
   output logic                  busy,
   output logic                  push_valid,
   output cfb_pkg::cfb_item_type push_item
);

   logic accept;
   logic is_upper;
   logic is_lower;

   assign busy     = queue_full;
   assign accept   = start & ~queue_full;
   assign is_upper = (req_in_byte >= cfb_pkg::UPPER_A) && (req_in_byte <= cfb_pkg::UPPER_Z);
   assign is_lower = (req_in_byte >= cfb_pkg::LOWER_A) && (req_in_byte <= cfb_pkg::LOWER_Z);

   always_comb begin
      push_item.op        = cfb_pkg::cfb_opcode_type'(req_opcode);
      push_item.is_letter = is_upper | is_lower;
      push_item.is_upper  = is_upper;
      push_item.raw       = req_in_byte;
      if (is_upper) begin
         push_item.letter = 5'(req_in_byte - cfb_pkg::UPPER_A);
      end else if (is_lower) begin
         push_item.letter = 5'(req_in_byte - cfb_pkg::LOWER_A);
      end else begin
         push_item.letter = 5'd0;
      end
      unique case (req_opcode)
         cfb_pkg::OP_COUNT,
         cfb_pkg::OP_DECRYPT,
         cfb_pkg::OP_CLEAR: push_valid = accept;
         default:           push_valid = 1'b0;
      endcase
   end

endmodule

// File: sv/cfb_queue.sv
// ----------------------------------------------------------------------------
// cfb_queue: short queue between front and back
// Holds classified transactions in order; the head is presented whenever the
// queue is not empty and is consumed in that same cycle.
// ----------------------------------------------------------------------------
module cfb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  cfb_pkg::cfb_item_type push_item,
   output logic                  full,
   output logic                  head_valid,
   output cfb_pkg::cfb_item_type head_item
);

   localparam int DEPTH = cfb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cfb_pkg::cfb_item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             pop;

   assign pop        = (fill_ff != '0);
   assign full       = (fill_ff == CNT_W'(DEPTH));
   assign head_valid = pop;
   assign head_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push_valid && pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: sv/cfb_back.sv
// ----------------------------------------------------------------------------
// cfb_back: histogram, running argmax and decryption
// Executes one queued transaction per cycle: saturating letter count with a
// running maximum, histogram clear, or a case-preserving shift back by the key.
// ----------------------------------------------------------------------------
module cfb_back #(
   parameter int COUNT_WIDTH = cfb_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  cfb_pkg::cfb_item_type item,
   output logic                  rsp_strobe,
   output logic [7:0]            rsp_out_byte,
   output logic [4:0]            rsp_key_shift
);

   logic [COUNT_WIDTH-1:0] counts_ff [cfb_pkg::LETTERS];
   logic [COUNT_WIDTH-1:0] best_count_ff, best_count_in;
   logic [4:0]             best_letter_ff, best_letter_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]             rsp_out_byte_ff, rsp_out_byte_in;
   logic [4:0]             rsp_key_shift_ff;

   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] new_count;
   logic                   do_count;
   logic                   do_clear;
   logic                   take_best;
   logic [4:0]             key;
   logic [5:0]             wrapped;
   logic [4:0]             plain_pos;
   logic [7:0]             base;

   assign cur_count = counts_ff[item.letter];
   assign new_count = (&cur_count) ? cur_count : cur_count + 1'b1;
   assign take_best = (new_count > best_count_ff) ||
                      ((new_count == best_count_ff) && (item.letter <= best_letter_ff));

   assign key = (best_letter_ff >= cfb_pkg::LETTER_E_IDX) ?
                best_letter_ff - cfb_pkg::LETTER_E_IDX :
                best_letter_ff + cfb_pkg::LETTER_COUNT - cfb_pkg::LETTER_E_IDX;

   assign wrapped   = {1'b0, item.letter} + {1'b0, cfb_pkg::LETTER_COUNT} - {1'b0, key};
   assign plain_pos = (item.letter >= key) ? item.letter - key : wrapped[4:0];
   assign base      = item.is_upper ? cfb_pkg::UPPER_A : cfb_pkg::LOWER_A;

   always_comb begin
      do_count        = 1'b0;
      do_clear        = 1'b0;
      rsp_strobe_in   = 1'b0;
      rsp_out_byte_in = item.raw;
      best_count_in   = best_count_ff;
      best_letter_in  = best_letter_ff;
      if (item_valid) begin
         unique case (item.op)
            cfb_pkg::OP_COUNT: begin
               do_count = item.is_letter;
               if (item.is_letter && take_best) begin
                  best_count_in  = new_count;
                  best_letter_in = item.letter;
               end
            end
            cfb_pkg::OP_DECRYPT: begin
               rsp_strobe_in = 1'b1;
               if (item.is_letter) begin
                  rsp_out_byte_in = base + {3'b000, plain_pos};
               end
            end
            cfb_pkg::OP_CLEAR: begin
               do_clear       = 1'b1;
               best_count_in  = '0;
               best_letter_in = '0;
            end
            default: begin
               do_count = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         for (int i = 0; i < cfb_pkg::LETTERS; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (do_count) begin
         counts_ff[item.letter] <= new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_count_ff  <= '0;
         best_letter_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         best_count_ff  <= best_count_in;
         best_letter_ff <= best_letter_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_byte_ff  <= rsp_out_byte_in;
      rsp_key_shift_ff <= key;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_key_shift = rsp_key_shift_ff;

endmodule

// File: sv/caesar_frequency_breaker_unit.sv
// ----------------------------------------------------------------------------
// caesar_frequency_breaker_unit: Caesar cipher breaker by letter frequency
// The block takes one transaction per clock cycle; busy stays low in normal
// use because the executing stage drains its two-entry queue every cycle. A
// decrypt transaction is written into the queue register, and its result then
// passes through the result register before it shows with rsp_strobe high.
// Count, clear and unused-opcode transactions give no result. The receiver
// cannot stall the block, and results appear in the order of the decrypt
// transactions.
// ----------------------------------------------------------------------------
module caesar_frequency_breaker_unit #(
   parameter int COUNT_WIDTH = cfb_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_in_byte,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_byte,
   output logic [4:0] rsp_key_shift
);

   cfb_pkg::cfb_item_type push_item;
   cfb_pkg::cfb_item_type head_item;
   logic                  push_valid;
   logic                  head_valid;
   logic                  queue_full;

   cfb_front u_front (
      .start       (start),
      .req_opcode  (req_opcode),
      .req_in_byte (req_in_byte),
      .queue_full  (queue_full),
      .busy        (busy),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   cfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   cfb_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (head_valid),
      .item          (head_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_key_shift (rsp_key_shift)
   );

endmodule
